>>> design/hrm_pkg.sv
package hrm_pkg;

    // Operation codes carried by the op field of an input beat.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_DIST     = 2'd0;
    localparam logic [1:0] CFG_SCALE_SECOND = 2'd1;
    localparam logic [1:0] CFG_SCALE_BEST   = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] MAX_DIST_RST     = 8'd80;
    localparam logic [7:0] SCALE_SECOND_RST = 8'd17;
    localparam logic [7:0] SCALE_BEST_RST   = 8'd20;

    // Fixed field widths of the ports.
    localparam int OP_W       = 2;
    localparam int WORD_W     = 64;
    localparam int IN_WORDS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 8;
    localparam int IDX_OUT_W  = 10;
    localparam int DIST_OUT_W = 9;
    localparam int CNT_OUT_W  = 11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic scan_issue;  // read the next stored entry
        logic mul;         // form the ratio-test products
        logic out_load;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic store_empty;
        logic scan_last;
        logic pipe_idle;
        logic out_free;
    } t_dp_status;

    // Population count of one 64-bit word, folded as a short adder tree.
    function automatic logic [6:0] pop64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [6:0]  p0, p1, p2, p3;
        a  = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        b  = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c  = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        p0 = 7'(c[7:0])   + 7'(c[15:8]);
        p1 = 7'(c[23:16]) + 7'(c[31:24]);
        p2 = 7'(c[39:32]) + 7'(c[47:40]);
        p3 = 7'(c[55:48]) + 7'(c[63:56]);
        return (p0 + p1) + (p2 + p3);
    endfunction

endpackage

>>> design/hrm_ctrl.sv
module hrm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [hrm_pkg::OP_W-1:0]  i_op,
    output logic                      o_in_ready,
    input  hrm_pkg::t_dp_status       i_status,
    output hrm_pkg::t_dp_cmd          o_cmd
);
    import hrm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.accept   = i_in_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_QUERY) begin
                        n_state = i_status.store_empty ? S_MUL : S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.pipe_idle) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new beat is only taken once the comparison pipeline has emptied.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_status.pipe_idle)
        else $error("controller idle while comparison pipeline busy");

    // A scan never runs over an empty set.
    a_scan_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_status.store_empty)
        else $error("scan started on an empty stored set");

endmodule

>>> design/hrm_datapath.sv
module hrm_datapath #(
    parameter int DESC_BITS   = 256,
    parameter int STORE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hrm_pkg::t_dp_cmd                   i_cmd,
    output hrm_pkg::t_dp_status                o_status,
    input  logic [hrm_pkg::OP_W-1:0]           i_op,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word0,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word1,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word2,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word3,
    input  logic                               i_cfg_write,
    input  logic [hrm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hrm_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_matched,
    output logic [hrm_pkg::IDX_OUT_W-1:0]      o_best_index,
    output logic [hrm_pkg::DIST_OUT_W-1:0]     o_best_distance,
    output logic [hrm_pkg::DIST_OUT_W-1:0]     o_second_distance,
    output logic                               o_dropped,
    output logic [hrm_pkg::CNT_OUT_W-1:0]      o_entry_count
);
    import hrm_pkg::*;

    localparam int DESC_WORDS = (DESC_BITS + 63) / 64;
    localparam int PAD_BITS   = DESC_WORDS * WORD_W;
    localparam int IN_BITS    = IN_WORDS * WORD_W;
    localparam int IDX_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
    localparam int DIST_W     = ($clog2(DESC_BITS + 1) > DIST_OUT_W) ?
                                $clog2(DESC_BITS + 1) : DIST_OUT_W;
    localparam int PROD_W     = DIST_W + CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_max_dist;
    logic [CFG_W-1:0] r_scale_second;
    logic [CFG_W-1:0] r_scale_best;

    // Stored set and its fill count.
    logic [DESC_BITS-1:0] r_mem [STORE_DEPTH];
    logic [CNT_W-1:0]     r_cnt;

    // Item registers.
    logic [OP_W-1:0]      r_op;
    logic [DESC_BITS-1:0] r_query;
    logic                 r_dropped;

    // Comparison pipeline.
    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]     r_idx1, r_idx2, r_idx3;
    logic [DESC_BITS-1:0] r_rd_data;
    logic [6:0]           r_wcnt [DESC_WORDS];
    logic [DIST_W-1:0]    r_dist;

    // Running best and second best.
    logic [DIST_W-1:0]    r_best;
    logic [DIST_W-1:0]    r_second;
    logic [IDX_W-1:0]     r_best_idx;
    logic [PROD_W-1:0]    r_prod_best;
    logic [PROD_W-1:0]    r_prod_second;

    // Result register.
    logic                  r_out_valid;
    logic                  r_matched;
    logic [IDX_OUT_W-1:0]  r_out_idx;
    logic [DIST_OUT_W-1:0] r_out_best;
    logic [DIST_OUT_W-1:0] r_out_second;
    logic                  r_out_dropped;
    logic [CNT_OUT_W-1:0]  r_out_cnt;

    logic [IN_BITS-1:0]             w_in_cat;
    logic [DESC_BITS+IN_BITS-1:0]   w_desc_ext;
    logic [DESC_BITS-1:0]           w_desc;
    logic [PAD_BITS+DESC_BITS-1:0]  w_xor_ext;
    logic [PAD_BITS-1:0]            w_xor;
    logic [DIST_W-1:0]              w_sum;
    logic [DIST_W-1:0]              w_start;
    logic                           w_full;
    logic                           w_is_query;
    logic [IDX_W+IDX_OUT_W-1:0]     w_idx_ext;
    logic [CNT_W+CNT_OUT_W-1:0]     w_cnt_ext;

    // Descriptor from the input words, widened or trimmed to DESC_BITS.
    assign w_in_cat   = {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
    assign w_desc_ext = {{DESC_BITS{1'b0}}, w_in_cat};
    assign w_desc     = w_desc_ext[DESC_BITS-1:0];

    assign w_full     = (r_cnt == CNT_W'(STORE_DEPTH));
    assign w_start    = DIST_W'({1'b0, r_max_dist} + 9'd1);
    assign w_is_query = (r_op == OP_QUERY);

    // Status towards the controller.
    assign o_status.store_empty = (r_cnt == '0);
    assign o_status.scan_last   = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_cnt);
    assign o_status.pipe_idle   = !r_v1 && !r_v2 && !r_v3;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist     <= MAX_DIST_RST;
            r_scale_second <= SCALE_SECOND_RST;
            r_scale_best   <= SCALE_BEST_RST;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_MAX_DIST:     r_max_dist     <= i_cfg_data;
                CFG_SCALE_SECOND: r_scale_second <= i_cfg_data;
                CFG_SCALE_BEST:   r_scale_best   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fill count, drop flag and latched op.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
            r_op      <= OP_CLEAR;
        end else if (i_cmd.accept) begin
            r_op      <= i_op;
            r_dropped <= (i_op == OP_APPEND) && w_full;
            if (i_op == OP_CLEAR) begin
                r_cnt <= '0;
            end else if ((i_op == OP_APPEND) && !w_full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Query descriptor holding register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_query <= w_desc;
        end
    end

    // Memory write port: appends go to the next free row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_op == OP_APPEND) && !w_full) begin
            r_mem[r_cnt[IDX_W-1:0]] <= w_desc;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    // Scan address and the valid/index bits travelling with each entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_scan_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
    end

    // Per-word bit counts of the difference.
    assign w_xor_ext = {{PAD_BITS{1'b0}}, r_rd_data ^ r_query};
    assign w_xor     = w_xor_ext[PAD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < DESC_WORDS; w++) begin
            r_wcnt[w] <= pop64(w_xor[w*WORD_W +: WORD_W]);
        end
    end

    // Sum of the word counts gives the Hamming distance.
    always_comb begin
        w_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++) begin
            w_sum = w_sum + DIST_W'(r_wcnt[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= w_sum;
    end

    // Best and second-best tracking; strict less-than keeps the first index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '0;
            r_second   <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.accept && (i_op == OP_QUERY)) begin
            r_best     <= w_start;
            r_second   <= w_start;
            r_best_idx <= '0;
        end else if (r_v3) begin
            if (r_dist < r_best) begin
                r_second   <= r_best;
                r_best     <= r_dist;
                r_best_idx <= r_idx3;
            end else if (r_dist < r_second) begin
                r_second <= r_dist;
            end
        end
    end

    // Ratio-test products, registered before the compare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_best   <= PROD_W'(r_best) * PROD_W'(r_scale_best);
            r_prod_second <= PROD_W'(r_second) * PROD_W'(r_scale_second);
        end
    end

    // Result register.
    assign w_idx_ext = {{IDX_OUT_W{1'b0}}, r_best_idx};
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_matched     <= w_is_query && (r_best <= DIST_W'(r_max_dist)) &&
                             (r_prod_best < r_prod_second);
            r_out_idx     <= w_is_query ? w_idx_ext[IDX_OUT_W-1:0] : '0;
            r_out_best    <= w_is_query ? r_best[DIST_OUT_W-1:0] : '0;
            r_out_second  <= w_is_query ? r_second[DIST_OUT_W-1:0] : '0;
            r_out_dropped <= r_dropped;
            r_out_cnt     <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_matched         = r_matched;
    assign o_best_index      = r_out_idx;
    assign o_best_distance   = r_out_best;
    assign o_second_distance = r_out_second;
    assign o_dropped         = r_out_dropped;
    assign o_entry_count     = r_out_cnt;

    // The fill count never passes the capacity.
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STORE_DEPTH))
        else $error("stored count beyond capacity");

    // The running best never exceeds the second best.
    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= r_second)
        else $error("best distance above second distance");

    // A refused append only happens on a full set.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> w_full)
        else $error("append dropped while the set had room");

endmodule

>>> design/hamming_ratio_matcher_top.sv
// Brute-force descriptor matcher with best/second-best ratio test.
// Input channel (i_in_valid / o_in_ready): one beat carries an op and a
// 256-bit descriptor in four 64-bit words. Op clear empties the stored set,
// op append writes the descriptor into the next free row (refused and
// flagged as dropped when the set is full), op query compares the descriptor
// with every stored row by Hamming distance.
// Output channel (o_out_valid / i_out_ready): one result beat per input beat.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the distance limit
// and the two ratio-test factors; it is always ready. It is to be written
// only while idle; the block itself does not enforce this. A clear, append
// or spare op goes from acceptance straight to the result load. A query over
// N stored rows is scanned through the single memory read port, which
// delivers one stored row per cycle into a four-stage compare pipeline,
// followed by a wait for it to drain, the multiply and the result load; a
// query on an empty set skips the scan. Items are taken one at a time; the
// next beat is accepted the cycle after the result register is loaded.
// When the receiver stalls a finished result, a further item is processed
// but waits before its own result load until the register is free.
// Reset empties the stored set and restores the configuration defaults;
// no clearing pass is needed since only written rows are ever read.
module hamming_ratio_matcher_top #(
    parameter int DESC_BITS   = 256,
    parameter int STORE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [hrm_pkg::OP_W-1:0]           i_op,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word0,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word1,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word2,
    input  logic [hrm_pkg::WORD_W-1:0]         i_desc_word3,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_matched,
    output logic [hrm_pkg::IDX_OUT_W-1:0]      o_best_index,
    output logic [hrm_pkg::DIST_OUT_W-1:0]     o_best_distance,
    output logic [hrm_pkg::DIST_OUT_W-1:0]     o_second_distance,
    output logic                               o_dropped,
    output logic [hrm_pkg::CNT_OUT_W-1:0]      o_entry_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hrm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hrm_pkg::CFG_W-1:0]          i_cfg_data
);
    import hrm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencing of each item.
    hrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Storage, distance pipeline and result register.
    hrm_datapath #(
        .DESC_BITS   (DESC_BITS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_op              (i_op),
        .i_desc_word0      (i_desc_word0),
        .i_desc_word1      (i_desc_word1),
        .i_desc_word2      (i_desc_word2),
        .i_desc_word3      (i_desc_word3),
        .i_cfg_write       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_matched         (o_matched),
        .o_best_index      (o_best_index),
        .o_best_distance   (o_best_distance),
        .o_second_distance (o_second_distance),
        .o_dropped         (o_dropped),
        .o_entry_count     (o_entry_count)
    );

endmodule

>>> bench/hamming_ratio_matcher_checker.sv
module hamming_ratio_matcher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [hrm_pkg::OP_W-1:0]       i_op,
    input  logic [hrm_pkg::WORD_W-1:0]     i_desc_word0,
    input  logic [hrm_pkg::WORD_W-1:0]     i_desc_word1,
    input  logic [hrm_pkg::WORD_W-1:0]     i_desc_word2,
    input  logic [hrm_pkg::WORD_W-1:0]     i_desc_word3,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_matched,
    input  logic [hrm_pkg::IDX_OUT_W-1:0]  i_best_index,
    input  logic [hrm_pkg::DIST_OUT_W-1:0] i_best_distance,
    input  logic [hrm_pkg::DIST_OUT_W-1:0] i_second_distance,
    input  logic                           i_dropped,
    input  logic [hrm_pkg::CNT_OUT_W-1:0]  i_entry_count,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [hrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hrm_pkg::CFG_W-1:0]      i_cfg_data,
    output int                             o_mismatch_count,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hrm_pkg::*;

    localparam int DESC_W    = WORD_W * IN_WORDS;
    localparam int STORE_CAP = 1024;

    // One result beat as the block should present it.
    typedef struct packed {
        logic                  matched;
        logic [IDX_OUT_W-1:0]  best_index;
        logic [DIST_OUT_W-1:0] best_distance;
        logic [DIST_OUT_W-1:0] second_distance;
        logic                  dropped;
        logic [CNT_OUT_W-1:0]  entry_count;
    } t_match_reply;

    // Our own copy of the stored set and the configuration registers.
    logic [DESC_W-1:0] descriptor_store [STORE_CAP];
    int unsigned       stored_total;
    logic [CFG_W-1:0]  max_distance;
    logic [CFG_W-1:0]  scale_second;
    logic [CFG_W-1:0]  scale_best;

    t_match_reply expected_replies [$];
    int           mismatches = 0;

    // Applies one input beat to the stored set and works out its result.
    function automatic t_match_reply compute_reply(input logic [OP_W-1:0] op,
                                                   input logic [DESC_W-1:0] desc);
        t_match_reply reply;
        int unsigned  best;
        int unsigned  second;
        int unsigned  distance;
        int unsigned  best_at;
        logic         found;
        reply   = '0;
        best_at = 0;
        found   = 1'b0;
        case (op)
            OP_CLEAR: begin
                stored_total = 0;
            end
            OP_APPEND: begin
                if (stored_total < STORE_CAP) begin
                    descriptor_store[stored_total] = desc;
                    stored_total++;
                end else begin
                    reply.dropped = 1'b1;
                end
            end
            OP_QUERY: begin
                // Both distances start one above the limit; strict less-than
                // keeps the lowest index when distances tie.
                best   = max_distance + 1;
                second = best;
                for (int unsigned j = 0; j < stored_total; j++) begin
                    distance = $countones(desc ^ descriptor_store[j]);
                    if (distance < best) begin
                        second  = best;
                        best    = distance;
                        best_at = j;
                        found   = 1'b1;
                    end else if (distance < second) begin
                        second = distance;
                    end
                end
                reply.matched = found && (best <= max_distance) &&
                                (best * scale_best < second * scale_second);
                reply.best_index      = IDX_OUT_W'(best_at);
                reply.best_distance   = DIST_OUT_W'(best);
                reply.second_distance = DIST_OUT_W'(second);
            end
            default: begin
                // The spare op code leaves everything as it was.
            end
        endcase
        reply.entry_count = CNT_OUT_W'(stored_total);
        return reply;
    endfunction

    // Compares one field and reports the first few differences.
    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("%0t ns: field %s expected %0d, got %0d", $time, field, want, got);
            end
            mismatches++;
        end
    endtask

    // Watch all three channels on the rising edge.
    always @(posedge i_clk) begin
        t_match_reply want;
        if (!i_rst_n) begin
            stored_total = 0;
            max_distance = MAX_DIST_RST;
            scale_second = SCALE_SECOND_RST;
            scale_best   = SCALE_BEST_RST;
            expected_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_DIST:     max_distance = i_cfg_data;
                    CFG_SCALE_SECOND: scale_second = i_cfg_data;
                    CFG_SCALE_BEST:   scale_best   = i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // The result beat belongs to an earlier input beat, so check first.
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t ns: result beat arrived with none outstanding", $time);
                    end
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("matched", 16'(want.matched), 16'(i_matched));
                    check_field("best_index", 16'(want.best_index), 16'(i_best_index));
                    check_field("best_distance", 16'(want.best_distance),
                                16'(i_best_distance));
                    check_field("second_distance", 16'(want.second_distance),
                                16'(i_second_distance));
                    check_field("dropped", 16'(want.dropped), 16'(i_dropped));
                    check_field("entry_count", 16'(want.entry_count), 16'(i_entry_count));
                end
            end

            if (i_in_valid && i_in_ready) begin
                expected_replies.push_back(compute_reply(i_op, {i_desc_word3, i_desc_word2,
                                                                i_desc_word1, i_desc_word0}));
            end
        end
        o_outstanding    <= expected_replies.size();
        o_mismatch_count <= mismatches;
    end

endmodule

>>> bench/hamming_ratio_matcher_top_tb.sv
module hamming_ratio_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int DESC_W       = WORD_W * IN_WORDS;
    localparam int STORE_CAP    = 1024;
    localparam int RANDOM_ITEMS = 510;
    localparam int CALM_ITEMS   = 60;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       in_op;
    logic [WORD_W-1:0]     in_word0;
    logic [WORD_W-1:0]     in_word1;
    logic [WORD_W-1:0]     in_word2;
    logic [WORD_W-1:0]     in_word3;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic                  matched;
    logic [IDX_OUT_W-1:0]  best_index;
    logic [DIST_OUT_W-1:0] best_distance;
    logic [DIST_OUT_W-1:0] second_distance;
    logic                  dropped;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int   mismatch_total;
    int   outstanding;
    logic quiet = 1'b0;
    int   items_sent = 0;
    int   rows_loaded = 0;
    int   stall_left = 0;

    always #2 clk = ~clk;

    hamming_ratio_matcher_top i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (in_op),
        .i_desc_word0      (in_word0),
        .i_desc_word1      (in_word1),
        .i_desc_word2      (in_word2),
        .i_desc_word3      (in_word3),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_matched         (matched),
        .o_best_index      (best_index),
        .o_best_distance   (best_distance),
        .o_second_distance (second_distance),
        .o_dropped         (dropped),
        .o_entry_count     (entry_count),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    hamming_ratio_matcher_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_op              (in_op),
        .i_desc_word0      (in_word0),
        .i_desc_word1      (in_word1),
        .i_desc_word2      (in_word2),
        .i_desc_word3      (in_word3),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_matched         (matched),
        .i_best_index      (best_index),
        .i_best_distance   (best_distance),
        .i_second_distance (second_distance),
        .i_dropped         (dropped),
        .i_entry_count     (entry_count),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatch_count  (mismatch_total),
        .o_outstanding     (outstanding)
    );

    // Receiver back-pressure: random ready levels, each held for a random stretch.
    always @(negedge clk) begin
        if (quiet) begin
            out_ready  = 1'b1;
            stall_left = 0;
        end else if (stall_left == 0) begin
            out_ready  = ($urandom_range(3, 0) != 0);
            stall_left = $urandom_range(15, 0);
        end else begin
            stall_left--;
        end
    end

    function automatic logic [DESC_W-1:0] rand_desc();
        logic [DESC_W-1:0] d;
        for (int k = 0; k < DESC_W / 32; k++) begin
            d[k*32 +: 32] = $urandom;
        end
        return d;
    endfunction

    function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d,
                                                    input int unsigned count);
        logic [DESC_W-1:0] r;
        r = d;
        repeat (count) begin
            r[$urandom_range(DESC_W - 1, 0)] ^= 1'b1;
        end
        return r;
    endfunction

    // Offers one input beat, with an occasional idle burst in front of it.
    // Valid is left high so the next beat can follow without a gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DESC_W-1:0] desc);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(4, 0) == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(16, 1);
            repeat (gap) @(negedge clk);
        end
        in_op    = op;
        {in_word3, in_word2, in_word1, in_word0} = desc;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (op == OP_CLEAR) begin
            rows_loaded = 0;
        end else if (op == OP_APPEND && rows_loaded < STORE_CAP) begin
            rows_loaded++;
        end
    endtask

    // Stops sending and waits until every outstanding result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic reconfigure(input logic [CFG_W-1:0] max_dist, input logic [CFG_W-1:0] num,
                               input logic [CFG_W-1:0] den);
        wait_drained();
        write_reg(CFG_MAX_DIST, max_dist);
        write_reg(CFG_SCALE_SECOND, num);
        write_reg(CFG_SCALE_BEST, den);
    endtask

    // Watchdog, well beyond the slowest correct run.
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [DESC_W-1:0] zeros;
        logic [DESC_W-1:0] ones;
        logic [DESC_W-1:0] stripes;
        logic [DESC_W-1:0] probe;
        logic [DESC_W-1:0] base;
        logic [DESC_W-1:0] pool [24];
        int                n_rows;
        int                n_queries;
        int                pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_op     = OP_CLEAR;
        in_word0  = '0;
        in_word1  = '0;
        in_word2  = '0;
        in_word3  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_DIST;
        cfg_data  = '0;
        zeros     = '0;
        ones      = '1;
        stripes   = {(DESC_W / 32){32'h5555_5555}};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset configuration.
        send_item(OP_QUERY, zeros);                   // empty set
        send_item(OP_SPARE, ones);                    // spare op code
        send_item(OP_APPEND, zeros);
        send_item(OP_APPEND, ones);
        send_item(OP_APPEND, stripes);
        send_item(OP_APPEND, flip_bits(zeros, 0) ^ {1'b1, {(DESC_W - 2){1'b0}}, 1'b1});
        send_item(OP_QUERY, zeros);
        send_item(OP_QUERY, ones);
        send_item(OP_APPEND, zeros);                  // duplicate row, tie on best
        send_item(OP_QUERY, zeros);
        send_item(OP_QUERY, stripes);
        send_item(OP_QUERY, zeros ^ (256'd1 << 128));
        send_item(OP_CLEAR, rand_desc());
        send_item(OP_QUERY, ones);                    // empty again after clear
        probe = rand_desc();
        send_item(OP_APPEND, probe);
        send_item(OP_QUERY, probe ^ ((256'd1 << 80) - 1));   // exactly on the limit
        send_item(OP_QUERY, probe ^ ((256'd1 << 81) - 1));   // one past it

        // Register extremes, including zero ratio terms.
        reconfigure(8'd0, 8'd1, 8'd1);
        send_item(OP_QUERY, probe);
        send_item(OP_QUERY, probe ^ 256'd1);
        reconfigure(8'd255, 8'd255, 8'd1);
        send_item(OP_APPEND, ones);
        send_item(OP_QUERY, zeros);
        send_item(OP_QUERY, ones);
        reconfigure(8'd80, 8'd0, 8'd20);
        send_item(OP_QUERY, probe);
        reconfigure(8'd80, 8'd17, 8'd0);
        send_item(OP_QUERY, probe);
        reconfigure(8'd255, 8'd255, 8'd255);
        send_item(OP_QUERY, flip_bits(probe, 5));
        reconfigure(MAX_DIST_RST, SCALE_SECOND_RST, SCALE_BEST_RST);
        send_item(OP_CLEAR, zeros);

        // Random episodes: load a small set, then query near copies of its rows,
        // with stray ops mixed in. The last stretch runs without idle gaps or stalls.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = (items_sent >= RANDOM_ITEMS - CALM_ITEMS) || ($urandom_range(3, 0) == 0);

            if ($urandom_range(2, 0) == 0) begin
                wait_drained();
                if ($urandom_range(3, 0) != 0) begin
                    write_reg(CFG_MAX_DIST, ($urandom_range(4, 0) == 0)
                              ? 8'($urandom_range(1, 0) * 255) : 8'($urandom_range(120, 20)));
                end
                if ($urandom_range(3, 0) != 0) begin
                    write_reg(CFG_SCALE_SECOND, ($urandom_range(4, 0) == 0)
                              ? 8'($urandom_range(255, 1)) : 8'($urandom_range(30, 8)));
                end
                if ($urandom_range(3, 0) != 0) begin
                    write_reg(CFG_SCALE_BEST, ($urandom_range(4, 0) == 0)
                              ? 8'($urandom_range(255, 1)) : 8'($urandom_range(30, 8)));
                end
            end

            if (rows_loaded > 200 || $urandom_range(6, 0) != 0) begin
                send_item(OP_CLEAR, rand_desc());
            end

            n_rows = $urandom_range(24, 1);
            base   = rand_desc();
            for (int i = 0; i < n_rows; i++) begin
                pool[i] = ($urandom_range(1, 0) == 0) ? flip_bits(base, $urandom_range(60, 0))
                                                      : rand_desc();
                send_item(OP_APPEND, pool[i]);
            end

            n_queries = $urandom_range(12, 1);
            for (int i = 0; i < n_queries; i++) begin
                pick = $urandom_range(9, 0);
                if (pick < 6) begin
                    send_item(OP_QUERY, flip_bits(pool[$urandom_range(n_rows - 1, 0)],
                                                  $urandom_range(40, 0)));
                end else if (pick == 6) begin
                    send_item(OP_QUERY, rand_desc());
                end else if (pick == 7) begin
                    send_item(OP_SPARE, rand_desc());
                end else if (pick == 8) begin
                    send_item(OP_APPEND, rand_desc());
                end else begin
                    send_item(OP_CLEAR, rand_desc());
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_total == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
